>>> hdl/slc_pkg.sv
// ----------------------------------------------------------------------------
// slc_pkg
// Shared widths, constants and types of the set-associative LRU cache lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slc_pkg;

  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Depths of the request queue (front to back) and of the result queue.
  localparam int REQ_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  // Control that the lookup engine hands back to the front end.
  typedef struct packed {
    logic init_busy;
    logic take;
  } slc_ctl_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [CNT_W-1:0]     misses;
    logic [CNT_W-1:0]     accesses;
  } slc_result_t;

endpackage : slc_pkg

`default_nettype wire

>>> hdl/slc_fifo.sv
// ----------------------------------------------------------------------------
// slc_fifo
// Small synchronous queue with registered storage and a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule : slc_fifo

`default_nettype wire

>>> hdl/slc_front.sv
// ----------------------------------------------------------------------------
// slc_front
// Accepts addresses, splits them into set index and tag, and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slc_front
  import slc_pkg::*;
#(
  parameter int OFFSET_BITS = 5,
  parameter int INDEX_BITS  = 6
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire logic [ADDR_W-1:0]     in_read_address,
  output logic                       in_full,
  input  wire slc_ctl_t              ctl,
  output logic                       req_valid,
  output logic [ADDR_W-OFFSET_BITS-INDEX_BITS-1:0] req_tag,
  output logic [((INDEX_BITS > 0) ? INDEX_BITS : 1)-1:0] req_set
);

  localparam int TAG_W = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int REQ_W = TAG_W + SET_W;

  logic [SET_W-1:0] set_idx;
  logic [REQ_W-1:0] q_rdata;
  logic             q_full;
  logic             q_empty;

  // The offset bits select nothing here and are dropped.
  generate
    if (INDEX_BITS > 0) begin : g_idx
      assign set_idx = in_read_address[OFFSET_BITS +: INDEX_BITS];
    end else begin : g_noidx
      assign set_idx = '0;
    end
  endgenerate

  // No item is taken while the lookup engine clears its recency memory.
  assign in_full = q_full || ctl.init_busy;

  slc_fifo #(
    .WIDTH (REQ_W),
    .DEPTH (REQ_QUEUE_DEPTH)
  ) u_req_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !ctl.init_busy),
    .wdata ({in_read_address[ADDR_W-1 -: TAG_W], set_idx}),
    .full  (q_full),
    .pop   (ctl.take),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign req_valid = !q_empty;
  assign req_tag   = q_rdata[REQ_W-1 -: TAG_W];
  assign req_set   = q_rdata[SET_W-1:0];

endmodule : slc_front

`default_nettype wire

>>> hdl/slc_back.sv
// ----------------------------------------------------------------------------
// slc_back
// Lookup engine: reads a set's tag and recency rows, picks the hit or victim
// way, writes back recency (and tags on a miss), updates saturating counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slc_back
  import slc_pkg::*;
#(
  parameter int OFFSET_BITS = 5,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS        = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  req_valid,
  input  wire logic [ADDR_W-OFFSET_BITS-INDEX_BITS-1:0] req_tag,
  input  wire logic [((INDEX_BITS > 0) ? INDEX_BITS : 1)-1:0] req_set,
  output slc_ctl_t                   ctl,
  input  wire logic                  res_full,
  output logic                       res_push,
  output slc_result_t                res_data
);

  localparam int TAG_W     = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int SET_W     = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int SET_COUNT = 1 << INDEX_BITS;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int REC_W     = WAYS * WAY_W;
  localparam int META_W    = WAYS + REC_W;
  localparam int ROW_W     = WAYS * TAG_W;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state_r;

  logic [SET_W-1:0] clr_idx_r;
  logic [SET_W-1:0] cur_set_r;
  logic [TAG_W-1:0] cur_tag_r;
  logic [CNT_W-1:0] miss_cnt_r;
  logic [CNT_W-1:0] acc_cnt_r;
  logic [CNT_W-1:0] miss_cnt_nxt;
  logic [CNT_W-1:0] acc_cnt_nxt;

  // Tag rows hold every way of a set; meta rows hold valid bits and the
  // recency order, most recently used way at position zero.
  logic [ROW_W-1:0]  tag_mem  [SET_COUNT];
  logic [META_W-1:0] meta_mem [SET_COUNT];
  logic [ROW_W-1:0]  tag_rd_r;
  logic [META_W-1:0] meta_rd_r;

  logic                        take;
  logic                        tag_we;
  logic [ROW_W-1:0]            tag_wdata;
  logic                        meta_we;
  logic [SET_W-1:0]            meta_waddr;
  logic [META_W-1:0]           meta_wdata;
  logic [META_W-1:0]           meta_init;

  logic [WAYS-1:0]             vld;
  logic [WAYS-1:0][WAY_W-1:0]  rec;
  logic [WAYS-1:0][TAG_W-1:0]  tags;
  logic [WAYS-1:0]             match;
  logic [WAYS-1:0]             pos_hit;
  logic [WAYS-1:0]             pos_inv;
  logic                        hit;
  logic [WAY_W-1:0]            hit_pos;
  logic [WAY_W-1:0]            victim_pos;
  logic [WAY_W-1:0]            sel_pos;
  logic [WAY_W-1:0]            sel_way;
  logic [WAYS-1:0]             new_vld;
  logic [WAYS-1:0][WAY_W-1:0]  new_rec;
  logic [WAYS-1:0][TAG_W-1:0]  new_tags;

  assign take            = (state_r == ST_IDLE) && req_valid && !res_full;
  assign ctl.take        = take;
  assign ctl.init_busy   = (state_r == ST_INIT);

  assign {vld, rec} = meta_rd_r;
  assign tags       = tag_rd_r;

  always_comb begin
    logic [WAYS-1:0][WAY_W-1:0] init_rec;
    for (int i = 0; i < WAYS; i++) begin
      init_rec[i] = WAY_W'(i);
    end
    meta_init = {{WAYS{1'b0}}, init_rec};
  end

  // Per-way compare, then the first match and first invalid way in
  // recency order.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld[w] && (tags[w] == cur_tag_r);
    end
    for (int p = 0; p < WAYS; p++) begin
      pos_hit[p] = match[rec[p]];
      pos_inv[p] = !vld[rec[p]];
    end
    hit        = |pos_hit;
    hit_pos    = '0;
    victim_pos = WAY_W'(WAYS - 1);
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (pos_hit[p]) begin
        hit_pos = WAY_W'(p);
      end
      if (pos_inv[p]) begin
        victim_pos = WAY_W'(p);
      end
    end
    sel_pos = hit ? hit_pos : victim_pos;
    sel_way = rec[sel_pos];
  end

  // Promote the chosen way to the front, shifting the ways ahead of it back.
  always_comb begin
    new_rec[0] = sel_way;
    for (int i = 1; i < WAYS; i++) begin
      new_rec[i] = (WAY_W'(i) <= sel_pos) ? rec[i-1] : rec[i];
    end
    new_vld          = vld;
    new_vld[sel_way] = 1'b1;
    new_tags          = tags;
    new_tags[sel_way] = cur_tag_r;
  end

  assign miss_cnt_nxt = (!hit && (miss_cnt_r != CNT_MAX)) ? miss_cnt_r + 1'b1 : miss_cnt_r;
  assign acc_cnt_nxt  = (acc_cnt_r != CNT_MAX) ? acc_cnt_r + 1'b1 : acc_cnt_r;

  assign tag_we     = (state_r == ST_LOOK) && !hit;
  assign tag_wdata  = new_tags;
  assign meta_we    = (state_r == ST_INIT) || (state_r == ST_LOOK);
  assign meta_waddr = (state_r == ST_INIT) ? clr_idx_r : cur_set_r;
  assign meta_wdata = (state_r == ST_INIT) ? meta_init : {new_vld, new_rec};

  assign res_push          = (state_r == ST_LOOK);
  assign res_data.hit      = hit;
  assign res_data.way      = WAY_OUT_W'(sel_way);
  assign res_data.misses   = miss_cnt_nxt;
  assign res_data.accesses = acc_cnt_nxt;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[cur_set_r] <= tag_wdata;
    end
    if (take) begin
      tag_rd_r <= tag_mem[req_set];
    end
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (take) begin
      meta_rd_r <= meta_mem[req_set];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      clr_idx_r  <= '0;
      miss_cnt_r <= '0;
      acc_cnt_r  <= '0;
    end else begin
      unique case (state_r)
        ST_INIT: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == SET_W'(SET_COUNT - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take) begin
            cur_set_r <= req_set;
            cur_tag_r <= req_tag;
            state_r   <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          miss_cnt_r <= miss_cnt_nxt;
          acc_cnt_r  <= acc_cnt_nxt;
          state_r    <= ST_IDLE;
        end
        default: begin
          state_r <= ST_INIT;
        end
      endcase
    end
  end

endmodule : slc_back

`default_nettype wire

>>> hdl/set_assoc_lru_cache_lookup.sv
// Path: an accepted item passes the request queue, the tag/recency row read
// registers and the result queue before it reaches the result ports.
// Issue: a new item is taken only once the last lookup has written back; each
// lookup reads the set's tag and recency rows as it is taken and writes them back in the next (tags only on a miss).
// Reset: counters clear at once; the recency/valid memory is then swept one set
// per cycle, all 2**INDEX_BITS sets (64 by default), while in_full stays high.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup
// Set-associative tag lookup with least-recently-used replacement and
// saturating access and miss counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_lookup
  import slc_pkg::*;
#(
  parameter int OFFSET_BITS = 5,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS        = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire logic [ADDR_W-1:0]    in_read_address,
  output logic                      in_full,
  input  wire logic                 out_pop,
  output logic                      out_empty,
  output logic                      out_hit,
  output logic [WAY_OUT_W-1:0]      out_way_used,
  output logic [CNT_W-1:0]          out_misses_so_far,
  output logic [CNT_W-1:0]          out_accesses_so_far
);

  localparam int TAG_W = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int RES_W = $bits(slc_result_t);

  slc_ctl_t          ctl;
  logic              req_valid;
  logic [TAG_W-1:0]  req_tag;
  logic [SET_W-1:0]  req_set;
  logic              res_full;
  logic              res_push;
  slc_result_t       res_data;
  slc_result_t       res_head;
  logic [RES_W-1:0]  res_rdata;

  slc_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_read_address (in_read_address),
    .in_full         (in_full),
    .ctl             (ctl),
    .req_valid       (req_valid),
    .req_tag         (req_tag),
    .req_set         (req_set)
  );

  slc_back #(
    .OFFSET_BITS (OFFSET_BITS),
    .INDEX_BITS  (INDEX_BITS),
    .WAYS        (WAYS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_tag   (req_tag),
    .req_set   (req_set),
    .ctl       (ctl),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  slc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign res_head            = slc_result_t'(res_rdata);
  assign out_hit             = res_head.hit;
  assign out_way_used        = res_head.way;
  assign out_misses_so_far   = res_head.misses;
  assign out_accesses_so_far = res_head.accesses;

endmodule : set_assoc_lru_cache_lookup

`default_nettype wire

>>> hdl/slc_checker.sv
// ----------------------------------------------------------------------------
// slc_checker
// Port-level checks of the cache lookup: counter sequence, result count and
// result stability under stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slc_checker
  import slc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_push,
  input  wire logic                 in_full,
  input  wire logic                 out_pop,
  input  wire logic                 out_empty,
  input  wire logic                 out_hit,
  input  wire logic [WAY_OUT_W-1:0] out_way_used,
  input  wire logic [CNT_W-1:0]     out_misses_so_far,
  input  wire logic [CNT_W-1:0]     out_accesses_so_far
);

  logic             in_acc;
  logic             out_acc;
  logic [CNT_W-1:0] prev_acc_r;
  logic [CNT_W-1:0] prev_miss_r;
  logic [3:0]       pending_r;
  logic [CNT_W-1:0] exp_acc;
  logic [CNT_W-1:0] exp_miss;

  assign in_acc   = in_push && !in_full;
  assign out_acc  = out_pop && !out_empty;
  assign exp_acc  = (prev_acc_r == CNT_MAX) ? CNT_MAX : prev_acc_r + 1'b1;
  assign exp_miss = (out_hit || (prev_miss_r == CNT_MAX)) ? prev_miss_r
                                                          : prev_miss_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_acc_r  <= '0;
      prev_miss_r <= '0;
      pending_r   <= '0;
    end else begin
      if (out_acc) begin
        prev_acc_r  <= out_accesses_so_far;
        prev_miss_r <= out_misses_so_far;
      end
      if (in_acc && !out_acc) begin
        pending_r <= pending_r + 1'b1;
      end else if (out_acc && !in_acc) begin
        pending_r <= pending_r - 1'b1;
      end
    end
  end

  // Each result counts one more access than the one before it, until the counter saturates.
  a_acc_seq: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_accesses_so_far == exp_acc)
    else $error("access counter out of sequence");

  // The miss counter moves only on a miss.
  a_miss_seq: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_misses_so_far == exp_miss)
    else $error("miss counter does not follow hit flag");

  // No result appears without an accepted item behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == '0 |-> out_empty)
    else $error("result without an accepted item");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty && $stable(out_hit) &&
      $stable(out_way_used) && $stable(out_misses_so_far) &&
      $stable(out_accesses_so_far))
    else $error("waiting result changed");

endmodule : slc_checker

bind set_assoc_lru_cache_lookup slc_checker u_slc_checker (.*);

`default_nettype wire

>>> sim/set_assoc_lru_cache_lookup_test.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_test
// Drives read addresses into the cache lookup and checks every result against
// a predictor that keeps its own tags, valid bits, LRU order and counters.
// The run starts with a short directed sequence and then sends random traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_lru_cache_lookup_test;
  import slc_pkg::*;

  localparam int OFFSET_BITS = 5;
  localparam int INDEX_BITS  = 6;
  localparam int WAYS        = 4;
  localparam int SET_COUNT   = 1 << INDEX_BITS;
  localparam int TAG_W       = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int RANDOM_ITEMS = 700;
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic [ADDR_W-1:0] in_read_address = '0;
  logic              in_full;
  logic              out_pop = 1'b0;
  logic              out_empty;
  logic              out_hit;
  logic [WAY_OUT_W-1:0] out_way_used;
  logic [CNT_W-1:0]  out_misses_so_far;
  logic [CNT_W-1:0]  out_accesses_so_far;

  // Predictor state.
  logic [TAG_W-1:0]  tag_ram [SET_COUNT][WAYS];
  logic              line_valid [SET_COUNT][WAYS];
  logic [1:0]        lru_order [SET_COUNT][WAYS];
  logic [CNT_W-1:0]  pred_misses;
  logic [CNT_W-1:0]  pred_accesses;

  logic [ADDR_W-1:0] lookup_addr_q [$];
  slc_result_t       expected_results [$];
  int                fail_count = 0;
  int                cycle_count = 0;
  int                in_gap = 0;
  int                out_gap = 0;
  logic              in_bursty = 1'b1;
  logic              out_bursty = 1'b1;

  set_assoc_lru_cache_lookup #(
    .OFFSET_BITS(OFFSET_BITS),
    .INDEX_BITS (INDEX_BITS),
    .WAYS       (WAYS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_read_address    (in_read_address),
    .in_full            (in_full),
    .out_pop            (out_pop),
    .out_empty          (out_empty),
    .out_hit            (out_hit),
    .out_way_used       (out_way_used),
    .out_misses_so_far  (out_misses_so_far),
    .out_accesses_so_far(out_accesses_so_far)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic clear_cache_model();
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        tag_ram[s][w]    = '0;
        line_valid[s][w] = 1'b0;
        lru_order[s][w]  = w[1:0];
      end
    end
    pred_misses   = '0;
    pred_accesses = '0;
  endtask

  // Looks the address up in the model, updates it and queues the result.
  task automatic predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [INDEX_BITS-1:0] set_idx;
    logic [TAG_W-1:0]      tag;
    logic                  found;
    logic                  have_free;
    int                    pos;
    logic [1:0]            way;
    slc_result_t           res;
    set_idx   = addr[OFFSET_BITS +: INDEX_BITS];
    tag       = addr[ADDR_W-1 -: TAG_W];
    found     = 1'b0;
    have_free = 1'b0;
    pos       = WAYS - 1;
    for (int p = 0; p < WAYS; p++) begin
      if (!found && line_valid[set_idx][lru_order[set_idx][p]] &&
          tag_ram[set_idx][lru_order[set_idx][p]] == tag) begin
        found = 1'b1;
        pos   = p;
      end
    end
    if (!found) begin
      if (pred_misses != CNT_MAX) pred_misses = pred_misses + 1;
      // Invalid ways sit behind valid ones, so the first one found is filled.
      for (int p = 0; p < WAYS; p++) begin
        if (!have_free && !line_valid[set_idx][lru_order[set_idx][p]]) begin
          have_free = 1'b1;
          pos       = p;
        end
      end
    end
    way = lru_order[set_idx][pos];
    for (int p = pos; p > 0; p--) lru_order[set_idx][p] = lru_order[set_idx][p-1];
    lru_order[set_idx][0] = way;
    if (!found) begin
      tag_ram[set_idx][way]    = tag;
      line_valid[set_idx][way] = 1'b1;
    end
    if (pred_accesses != CNT_MAX) pred_accesses = pred_accesses + 1;
    res.hit      = found;
    res.way      = way;
    res.misses   = pred_misses;
    res.accesses = pred_accesses;
    expected_results.push_back(res);
  endtask

  function automatic logic [ADDR_W-1:0] make_addr(input int tag,
                                                  input int set_idx, input int offs);
    logic [ADDR_W-1:0] a;
    a = {tag[TAG_W-1:0], set_idx[INDEX_BITS-1:0], offs[OFFSET_BITS-1:0]};
    return a;
  endfunction

  // Driver: takes addresses from the pending queue and pushes them.
  always @(posedge clk) begin
    logic              push_nxt;
    logic [ADDR_W-1:0] addr_nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      push_nxt = in_push;
      addr_nxt = in_read_address;
      if (in_push && !in_full) begin
        predict_lookup(in_read_address);
        push_nxt = 1'b0;
        if ($urandom_range(0, 63) == 0) in_bursty = ~in_bursty;
      end
      if (!push_nxt) begin
        addr_nxt = $urandom;
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
        end else if (lookup_addr_q.size() > 0) begin
          if (in_bursty && lookup_addr_q.size() > QUIET_TAIL &&
              $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(0, 9);
          end else begin
            push_nxt = 1'b1;
            addr_nxt = lookup_addr_q.pop_front();
          end
        end
      end
      in_push         <= push_nxt;
      in_read_address <= addr_nxt;
    end
  end

  // Monitor: pops results and compares them with the oldest expectation.
  always @(posedge clk) begin
    slc_result_t exp_res;
    logic        pop_nxt;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result item with none expected: hit %0d way %0d",
                   $time, out_hit, out_way_used);
          $display("%0t: misses %0d accesses %0d", $time, out_misses_so_far,
                   out_accesses_so_far);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_hit !== exp_res.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, exp_res.hit, out_hit);
            fail_count++;
          end
          if (out_way_used !== exp_res.way) begin
            $display("%0t: way_used expected %0d actual %0d", $time, exp_res.way,
                     out_way_used);
            fail_count++;
          end
          if (out_misses_so_far !== exp_res.misses) begin
            $display("%0t: misses_so_far expected %0d actual %0d", $time, exp_res.misses,
                     out_misses_so_far);
            fail_count++;
          end
          if (out_accesses_so_far !== exp_res.accesses) begin
            $display("%0t: accesses_so_far expected %0d actual %0d", $time,
                     exp_res.accesses, out_accesses_so_far);
            fail_count++;
          end
        end
        if ($urandom_range(0, 63) == 0) out_bursty = ~out_bursty;
      end
      pop_nxt = 1'b1;
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        pop_nxt = 1'b0;
      end else if (out_bursty && lookup_addr_q.size() > QUIET_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 9);
        pop_nxt = 1'b0;
      end
      out_pop <= pop_nxt;
    end
  end

  initial begin
    logic [TAG_W-1:0] tag_pool [6];
    int               set_pool [4];
    clear_cache_model();

    // Directed part: address extremes, offsets, fill and eviction in one set.
    lookup_addr_q.push_back(32'h0000_0000);
    lookup_addr_q.push_back(32'h0000_001F);
    lookup_addr_q.push_back(32'hFFFF_FFFF);
    lookup_addr_q.push_back(32'hFFFF_FFE0);
    for (int t = 1; t <= 4; t++) lookup_addr_q.push_back(make_addr(t, 5, 0));
    lookup_addr_q.push_back(make_addr(1, 5, 3));
    lookup_addr_q.push_back(make_addr(5, 5, 0));
    lookup_addr_q.push_back(make_addr(2, 5, 31));
    lookup_addr_q.push_back(make_addr(4, 5, 7));
    lookup_addr_q.push_back(make_addr(1, 5, 0));
    lookup_addr_q.push_back(make_addr(5, 5, 1));
    lookup_addr_q.push_back(make_addr(1, 6, 0));
    lookup_addr_q.push_back(32'h8000_0000);
    lookup_addr_q.push_back(32'h7FFF_FFFF);
    lookup_addr_q.push_back(32'h5555_5555);
    lookup_addr_q.push_back(32'hAAAA_AAAA);
    lookup_addr_q.push_back(32'h0000_0000);

    // Random part: mostly a few sets and tags so that hits and evictions
    // are frequent, with some fully random addresses mixed in.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = TAG_W'($urandom);
    for (int i = 0; i < 4; i++) set_pool[i] = $urandom_range(0, SET_COUNT - 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        lookup_addr_q.push_back(make_addr(tag_pool[$urandom_range(0, 5)],
                                          set_pool[$urandom_range(0, 3)],
                                          $urandom_range(0, (1 << OFFSET_BITS) - 1)));
      end else begin
        lookup_addr_q.push_back($urandom);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (lookup_addr_q.size() > 0 || in_push || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS set_assoc_lru_cache_lookup");
    end else begin
      $display("FAIL set_assoc_lru_cache_lookup");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL set_assoc_lru_cache_lookup");
    $finish;
  end

endmodule
